// ===== rtl/core/mhb_pkg.sv =====
package mhb_pkg;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_BUILD_INIT,
		OP_NODE_RD,
		OP_NODE_CAP,
		OP_CHILD_RD,
		OP_CHILD_CMP,
		OP_PLACE,
		OP_NEXT_NODE,
		OP_EMIT_RD,
		OP_EMIT_CAP,
		OP_EMIT_NEXT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic node_zero;
		logic swap;
		logic big_has_child;
		logic emit_last;
	} status_t;

endpackage

// ===== rtl/core/mhb_dp.sv =====
module mhb_dp import mhb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  logic signed [31:0] value,
	output status_t            status,
	output logic signed [31:0] element,
	output logic               final_res,
	output logic               overflow
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_a_q, rd_b_q, cur_q, elem_q;
	logic [CW-1:0]      cnt_q, node_q, pos_q, emit_q;
	logic               drop_q, final_q, ovf_q;

	logic [CW:0]        lchild, rchild;
	logic [CW-1:0]      node_m1, pos_m1, emit_m1, lchild_m1, big_pos;
	logic               r_ok, take_r, swap, not_full;
	logic signed [31:0] big_val;
	logic [AW-1:0]      raddr_a, raddr_b, waddr;
	logic signed [31:0] wdata;
	logic               we;

	assign lchild    = {pos_q, 1'b0};
	assign rchild    = {pos_q, 1'b1};
	assign node_m1   = node_q - CW'(1);
	assign pos_m1    = pos_q - CW'(1);
	assign emit_m1   = emit_q - CW'(1);
	assign lchild_m1 = lchild[CW-1:0] - CW'(1);
	assign not_full  = cnt_q < CW'(DEPTH);

	assign r_ok    = rchild <= {1'b0, cnt_q};
	assign take_r  = r_ok && (rd_b_q > rd_a_q);
	assign big_val = take_r ? rd_b_q : rd_a_q;
	assign big_pos = take_r ? rchild[CW-1:0] : lchild[CW-1:0];
	assign swap    = big_val > cur_q;

	assign status.node_zero     = node_q == '0;
	assign status.swap          = swap;
	assign status.big_has_child = {big_pos, 1'b0} <= {1'b0, cnt_q};
	assign status.emit_last     = emit_q == cnt_q;

	always_comb begin
		case (op)
			OP_NODE_RD:  raddr_a = node_m1[AW-1:0];
			OP_CHILD_RD: raddr_a = lchild_m1[AW-1:0];
			OP_EMIT_RD:  raddr_a = emit_m1[AW-1:0];
			default:     raddr_a = '0;
		endcase
	end

	assign raddr_b = lchild[AW-1:0];

	always_comb begin
		case (op)
			OP_LOAD: begin
				we    = not_full;
				waddr = cnt_q[AW-1:0];
				wdata = value;
			end
			OP_CHILD_CMP: begin
				we    = 1'b1;
				waddr = pos_m1[AW-1:0];
				wdata = swap ? big_val : cur_q;
			end
			OP_PLACE: begin
				we    = 1'b1;
				waddr = pos_m1[AW-1:0];
				wdata = cur_q;
			end
			default: begin
				we    = 1'b0;
				waddr = '0;
				wdata = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			node_q <= '0;
			emit_q <= '0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (not_full) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						drop_q <= 1'b1;
					end
				end
				OP_BUILD_INIT: begin
					node_q <= cnt_q >> 1;
					emit_q <= CW'(1);
				end
				OP_NEXT_NODE: node_q <= node_m1;
				OP_EMIT_NEXT: emit_q <= emit_q + CW'(1);
				OP_CLEAR: begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_NODE_RD:  pos_q <= node_q;
			OP_NODE_CAP: cur_q <= rd_a_q;
			OP_CHILD_CMP: begin
				if (swap) begin
					pos_q <= big_pos;
				end
			end
			OP_EMIT_CAP: begin
				elem_q  <= rd_a_q;
				final_q <= emit_q == cnt_q;
				ovf_q   <= drop_q;
			end
			default: ;
		endcase
	end

	assign element   = elem_q;
	assign final_res = final_q;
	assign overflow  = ovf_q;

endmodule

// ===== rtl/core/mhb_ctrl.sv =====
module mhb_ctrl import mhb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	input  logic    out_stall,
	input  status_t status,
	output logic    in_stall,
	output logic    out_valid,
	output op_t     op
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_BUILD_INIT,
		S_NODE_CHK,
		S_NODE_RD,
		S_NODE_CAP,
		S_CHILD_RD,
		S_CHILD_CMP,
		S_PLACE,
		S_NEXT_NODE,
		S_EMIT_RD,
		S_EMIT_CAP,
		S_EMIT_HOLD
	} state_t;

	state_t state_q;
	logic   in_stall_q, out_valid_q;
	logic   in_beat;

	assign in_beat   = in_valid && !in_stall_q;
	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

	always_comb begin
		case (state_q)
			S_LOAD:       op = in_beat ? OP_LOAD : OP_NONE;
			S_BUILD_INIT: op = OP_BUILD_INIT;
			S_NODE_RD:    op = OP_NODE_RD;
			S_NODE_CAP:   op = OP_NODE_CAP;
			S_CHILD_RD:   op = OP_CHILD_RD;
			S_CHILD_CMP:  op = OP_CHILD_CMP;
			S_PLACE:      op = OP_PLACE;
			S_NEXT_NODE:  op = OP_NEXT_NODE;
			S_EMIT_RD:    op = OP_EMIT_RD;
			S_EMIT_CAP:   op = OP_EMIT_CAP;
			S_EMIT_HOLD: begin
				if (out_stall) begin
					op = OP_NONE;
				end else if (status.emit_last) begin
					op = OP_CLEAR;
				end else begin
					op = OP_EMIT_NEXT;
				end
			end
			default:      op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_beat && in_last) begin
						state_q    <= S_BUILD_INIT;
						in_stall_q <= 1'b1;
					end
				end
				S_BUILD_INIT: state_q <= S_NODE_CHK;
				S_NODE_CHK:   state_q <= status.node_zero ? S_EMIT_RD : S_NODE_RD;
				S_NODE_RD:    state_q <= S_NODE_CAP;
				S_NODE_CAP:   state_q <= S_CHILD_RD;
				S_CHILD_RD:   state_q <= S_CHILD_CMP;
				S_CHILD_CMP: begin
					if (!status.swap) begin
						state_q <= S_NEXT_NODE;
					end else if (status.big_has_child) begin
						state_q <= S_CHILD_RD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE:      state_q <= S_NEXT_NODE;
				S_NEXT_NODE:  state_q <= S_NODE_CHK;
				S_EMIT_RD:    state_q <= S_EMIT_CAP;
				S_EMIT_CAP: begin
					state_q     <= S_EMIT_HOLD;
					out_valid_q <= 1'b1;
				end
				S_EMIT_HOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (status.emit_last) begin
							state_q    <= S_LOAD;
							in_stall_q <= 1'b0;
						end else begin
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== rtl/core/max_heap_build.sv =====
// max_heap_build: collects a batch of signed 32-bit values and returns it
// rearranged as a binary max-heap in array order, root first.
// input channel: value and last, moved by in_valid / in_stall. one beat is
// taken per cycle while loading; the beat with last set closes the batch.
// beats beyond DEPTH are dropped and reported on overflow.
// after the closing beat in_stall stays high while the heap is built and
// emitted. building sifts each internal node down through one memory with
// one write and two read ports: setup, then per node a fetch and a read
// and compare of its children, another read and compare per further level
// it moves, a place step at rest on a leaf, then a step to the next node.
// output channel: element, final_res, overflow, moved by out_valid /
// out_stall. each element goes through a memory read, the output register
// and its beat, plus any stall by the receiver; the output holds while
// out_stall is high. final_res marks the last beat of the batch.
// the cycle after that beat in_stall drops and the next batch may load.
// reset (arst_n low) empties the batch and returns to loading; the store
// needs no clearing pass.
module max_heap_build import mhb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] element,
	output logic               final_res,
	output logic               overflow
);

	op_t     op;
	status_t status;

	mhb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (last),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.op        (op)
	);

	mhb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value     (value),
		.status    (status),
		.element   (element),
		.final_res (final_res),
		.overflow  (overflow)
	);

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	a_last_closes_batch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall && !out_valid)
		else $error("closing beat did not stop loading");

	a_final_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && final_res |=> !in_stall && !out_valid)
		else $error("final beat did not return to loading");

	a_beat_rereads: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !final_res |=> !out_valid && in_stall)
		else $error("emission did not advance after a beat");

endmodule

// ===== tb/tb.sv =====
module tb;
	localparam int STORE_DEPTH = 64;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic signed [31:0] element;
		logic               final_res;
		logic               overflow;
	} heap_beat_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] value;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] element;
	logic               final_res;
	logic               overflow;

	// predicted store, fill level and drop flag of the batch being loaded
	logic signed [31:0] heap_mem [1:STORE_DEPTH];
	int                 fill = 0;
	bit                 spilled = 0;
	heap_beat_t         heap_q [$];
	logic signed [31:0] load_q [$];

	int errors = 0;
	int beats_in = 0;
	int beats_checked = 0;
	int heaps_checked = 0;
	int spilled_heaps = 0;
	int hold_req = 0;
	bit calm = 0;

	max_heap_build #(.DEPTH(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element(element),
		.final_res(final_res),
		.overflow(overflow)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void sift(input int start, input int n);
		int                 pos;
		int                 big;
		bit                 go;
		logic signed [31:0] t;
		pos = start;
		go = 1;
		while (go && 2 * pos <= n) begin
			big = 2 * pos;
			if (big + 1 <= n && heap_mem[big + 1] > heap_mem[big])
				big = big + 1;
			if (heap_mem[big] > heap_mem[pos]) begin
				t = heap_mem[big];
				heap_mem[big] = heap_mem[pos];
				heap_mem[pos] = t;
				pos = big;
			end else
				go = 0;
		end
	endfunction

	function automatic void take_beat(input logic signed [31:0] v, input logic l);
		heap_beat_t b;
		if (fill < STORE_DEPTH) begin
			fill++;
			heap_mem[fill] = v;
		end else
			spilled = 1;
		if (l) begin
			for (int i = fill / 2; i >= 1; i--)
				sift(i, fill);
			for (int i = 1; i <= fill; i++) begin
				b.element = heap_mem[i];
				b.final_res = (i == fill);
				b.overflow = spilled;
				heap_q.push_back(b);
			end
			if (spilled)
				spilled_heaps++;
			fill = 0;
			spilled = 0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			take_beat(value, last);
			beats_in++;
		end
	end

	always @(posedge clk) begin : check_out
		heap_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (heap_q.size() == 0)
				report($sformatf("unexpected beat, element %0d", element));
			else begin
				want = heap_q.pop_front();
				beats_checked++;
				if (element !== want.element)
					report($sformatf("element %0d, want %0d", element, want.element));
				if (final_res !== want.final_res)
					report($sformatf("final_res %b, want %b", final_res, want.final_res));
				if (overflow !== want.overflow)
					report($sformatf("overflow %b, want %b", overflow, want.overflow));
				if (want.final_res)
					heaps_checked++;
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_stall <= 1'b1;
				hold_req--;
			end else
				out_stall <= !calm && $urandom_range(99) < 22;
		end
	end

	task automatic send_beat(input logic signed [31:0] v, input logic l);
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic push_batch();
		int n;
		n = load_q.size();
		for (int i = 0; i < n; i++)
			send_beat(load_q[i], i == n - 1);
		load_q.delete();
	endtask

	task automatic await_heaps();
		in_valid <= 1'b0;
		@(posedge clk);
		while (heap_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4, 5: return $signed($urandom_range(6)) - 32'sd3;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 92)
			return $urandom_range(9, 24);
		return $urandom_range(25, STORE_DEPTH);
	endfunction

	task automatic fill_random(input int n);
		for (int i = 0; i < n; i++)
			load_q.push_back(pick_value());
	endtask

	task automatic test_tiny_batches();
		load_q.push_back(S32_MAX);
		push_batch();
		load_q.push_back(S32_MIN);
		push_batch();
		load_q.push_back(S32_MIN);
		load_q.push_back(S32_MAX);
		push_batch();
		load_q.push_back(S32_MAX);
		load_q.push_back(S32_MAX);
		push_batch();
	endtask

	// equal children pick the left one, equal parent and child never swap
	task automatic test_ties();
		load_q.push_back(32'sd3);
		load_q.push_back(32'sd5);
		load_q.push_back(32'sd5);
		push_batch();
		load_q.push_back(32'sd2);
		load_q.push_back(32'sd2);
		load_q.push_back(32'sd9);
		push_batch();
		repeat (4)
			load_q.push_back(-32'sd4);
		push_batch();
	endtask

	task automatic test_extremes();
		load_q.push_back(S32_MIN);
		load_q.push_back(-32'sd1);
		load_q.push_back(32'sd0);
		load_q.push_back(32'sd1);
		load_q.push_back(S32_MAX);
		load_q.push_back(S32_MAX);
		load_q.push_back(S32_MIN);
		load_q.push_back(32'sd7);
		push_batch();
	endtask

	task automatic test_random_batches();
		int sent;
		sent = 0;
		while (sent < 180) begin
			fill_random(pick_size());
			sent += load_q.size();
			push_batch();
		end
	endtask

	// exactly full, then full with the last beat among the dropped ones, then a small batch
	task automatic test_overflow();
		fill_random(STORE_DEPTH);
		push_batch();
		fill_random(STORE_DEPTH + 2);
		push_batch();
		fill_random(3);
		push_batch();
	endtask

	task automatic test_streaming();
		calm = 1;
		repeat (8) begin
			fill_random($urandom_range(2, 8));
			push_batch();
		end
		calm = 0;
	endtask

	task automatic test_backpressure();
		hold_req = 300;
		fill_random(8);
		push_batch();
		fill_random(8);
		push_batch();
	endtask

	task automatic test_pause();
		fill_random(5);
		push_batch();
		await_heaps();
		fill_random(5);
		push_batch();
		await_heaps();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tiny_batches();
		test_ties();
		test_extremes();
		test_random_batches();
		test_overflow();
		test_streaming();
		test_backpressure();
		test_pause();
		await_heaps();
		repeat (30) @(posedge clk);
		$display("%0d beats loaded, %0d heap elements checked in %0d heaps", beats_in,
			beats_checked, heaps_checked);
		$display("%0d heaps had dropped beats; ties, extremes and long stalls included",
			spilled_heaps);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: errors");
		$finish;
	end
endmodule
